/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define SAPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sapa checker: property failed");

// Condition in one cycle that implies a condition in the next.
`define SAPA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sapa checker: next-cycle property failed");

`endif

/* rtl/sapa_pkg.sv */
package sapa_pkg;

    localparam int WORD_BITS = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_NOT_USED  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SUBNET_PREFIX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LENGTH = 8'd1;

    typedef struct packed {
        logic clr_wr;
        logic clr_done;
        logic accept;
        logic rd;
        logic next;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic is_last;
        logic is_free;
        logic clr_last;
        logic out_free;
        logic rebuild;
    } t_dp_sts;

endpackage

/* rtl/sapa_ctl.sv */
module sapa_ctl
    import sapa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    o_cmd.clr_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.is_free && !i_sts.hit && !i_sts.is_last) begin
                    o_cmd.next = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
        endcase
        if (i_sts.rebuild) begin
            n_state = S_CLR;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/sapa_dp.sv */
module sapa_dp
    import sapa_pkg::*;
#(
    parameter int MAX_HOST_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic                 i_in_cmd,
    input  logic [31:0]          i_in_addr,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [31:0]          o_res_addr,
    output logic [1:0]           o_status,
    output logic [10:0]          o_free_count
);

    localparam int POOL_MAX   = 1 << MAX_HOST_BITS;
    localparam int WORD_COUNT = (POOL_MAX + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int HBW        = $clog2(MAX_HOST_BITS + 1);
    localparam int CNTW       = MAX_HOST_BITS + 1;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(WORD_COUNT - 1);

    function automatic logic [HBW-1:0] clamp_bits(input logic [4:0] pl);
        logic [5:0] h;
        h = 6'd32 - {1'b0, pl};
        if (h < 6'd2) begin
            h = 6'd2;
        end else if (h > 6'(MAX_HOST_BITS)) begin
            h = 6'(MAX_HOST_BITS);
        end
        return h[HBW-1:0];
    endfunction

    logic [WORD_BITS-1:0] mem [WORD_COUNT];

    logic [31:0]            r_prefix;
    logic [HBW-1:0]         r_hbits;
    logic [CNTW-1:0]        r_free;
    logic [CNTW-1:0]        n_free;
    logic [WAW-1:0]         r_sw;
    logic                   r_cmd;
    logic [WAW-1:0]         r_word;
    logic [WORD_BITS-1:0]   r_mask;
    logic [5:0]             r_bit;
    logic [WORD_BITS-1:0]   r_rdata;
    logic                   r_out_valid;
    logic [31:0]            r_res_addr;
    logic [1:0]             r_status;
    logic [10:0]            r_out_cnt;

    logic [MAX_HOST_BITS-1:0]   host_mask;
    logic [MAX_HOST_BITS-1:0]   in_host;
    logic [MAX_HOST_BITS+5:0]   in_host_x;
    logic [CNTW-1:0]            pool;
    logic [CNTW-1:0]            pool_sh;
    logic [WAW:0]               pool_words;
    logic [CNTW+5:0]            pool_x;
    logic [CNTW+5:0]            pm1_x;
    logic [CNTW+5:0]            pm2_x;
    logic [WAW-1:0]             last_word;
    logic [WORD_BITS-1:0]       fill;
    logic [WORD_BITS-1:0]       cand;
    logic [WORD_BITS-1:0]       iso;
    logic [5:0]                 idx;
    logic                       hit;
    logic [WAW+5:0]             found_x;
    logic [MAX_HOST_BITS-1:0]   found;
    logic [31:0]                hm32;
    logic [31:0]                found32;
    logic [WORD_BITS-1:0]       free_bit;
    logic                       used;
    logic                       wr_en;
    logic [WAW-1:0]             wr_addr;
    logic [WORD_BITS-1:0]       wr_data;
    logic [WAW-1:0]             rd_addr;
    logic [31:0]                res_addr;
    logic [1:0]                 res_status;
    logic [CNTW+10:0]           free_x;
    logic                       rebuild;

    assign rebuild   = i_cfg_valid && (i_cfg_index == REG_PREFIX_LENGTH);
    assign host_mask = ~({MAX_HOST_BITS{1'b1}} << r_hbits);
    assign in_host   = i_in_addr[MAX_HOST_BITS-1:0] & host_mask;
    assign in_host_x = {6'b0, in_host};

    assign pool       = CNTW'(1) << r_hbits;
    assign pool_sh    = pool >> 6;
    assign pool_words = pool_sh[WAW:0];
    assign pool_x     = {6'b0, pool};
    assign pm1_x      = {6'b0, pool - CNTW'(1)};
    assign pm2_x      = {6'b0, pool - CNTW'(2)};
    assign last_word  = pm1_x[6 +: WAW];

    always_comb begin
        if ({1'b0, r_sw} < pool_words) begin
            fill = '0;
        end else if ((pool_words == '0) && (r_sw == '0)) begin
            fill = {WORD_BITS{1'b1}} << pool_x[5:0];
        end else begin
            fill = {WORD_BITS{1'b1}};
        end
        if (r_sw == '0) begin
            fill[0] = 1'b1;
        end
        if (r_sw == last_word) begin
            fill[pm1_x[5:0]] = 1'b1;
            fill[pm2_x[5:0]] = 1'b1;
        end
    end

    assign cand = ~r_rdata & r_mask;
    assign iso  = cand & (~cand + 64'd1);
    assign hit  = |cand;

    always_comb begin
        idx = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (iso[b]) begin
                idx = idx | 6'(b);
            end
        end
    end

    assign found_x  = {r_word, idx};
    assign found    = found_x[MAX_HOST_BITS-1:0];
    assign hm32     = {{(32-MAX_HOST_BITS){1'b0}}, host_mask};
    assign found32  = {{(32-MAX_HOST_BITS){1'b0}}, found};
    assign free_bit = 64'd1 << r_bit;
    assign used     = |(r_rdata & free_bit);

    always_comb begin
        n_free     = r_free;
        wr_en      = 1'b0;
        wr_addr    = r_word;
        wr_data    = r_rdata;
        res_addr   = '0;
        res_status = ST_OK;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_sw;
            wr_data = fill;
        end
        if (i_cmd.finish) begin
            if (r_cmd == CMD_ALLOC) begin
                if (hit) begin
                    wr_en    = 1'b1;
                    wr_data  = r_rdata | iso;
                    n_free   = r_free - CNTW'(1);
                    res_addr = (r_prefix & ~hm32) | found32;
                end else begin
                    res_status = ST_EXHAUSTED;
                end
            end else begin
                if (used) begin
                    wr_en   = 1'b1;
                    wr_data = r_rdata & ~free_bit;
                    n_free  = r_free + CNTW'(1);
                end else begin
                    res_status = ST_NOT_USED;
                end
            end
        end
        if (i_cmd.clr_done) begin
            n_free = pool - CNTW'(3);
        end
    end

    assign free_x  = {11'b0, n_free};
    assign rd_addr = i_cmd.next ? (r_word + WAW'(1)) : r_word;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd || i_cmd.next) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix    <= '0;
            r_hbits     <= clamp_bits(5'd24);
            r_free      <= '0;
            r_sw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == REG_SUBNET_PREFIX)) begin
                r_prefix <= i_cfg_data;
            end
            if (rebuild) begin
                r_hbits <= clamp_bits(i_cfg_data[4:0]);
                r_sw    <= '0;
            end else if (i_cmd.clr_wr) begin
                r_sw <= r_sw + WAW'(1);
            end
            r_free <= n_free;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_in_cmd;
            r_word <= in_host_x[6 +: WAW];
            r_mask <= {WORD_BITS{1'b1}} << in_host_x[5:0];
            r_bit  <= in_host_x[5:0];
        end else if (i_cmd.next) begin
            r_word <= r_word + WAW'(1);
            r_mask <= {WORD_BITS{1'b1}};
        end
        if (i_cmd.finish) begin
            r_res_addr <= res_addr;
            r_status   <= res_status;
            r_out_cnt  <= free_x[10:0];
        end
    end

    assign o_sts.hit      = hit;
    assign o_sts.is_last  = (r_word == LAST_WORD);
    assign o_sts.is_free  = (r_cmd == CMD_FREE);
    assign o_sts.clr_last = (r_sw == LAST_WORD);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.rebuild  = rebuild;

    assign o_out_valid  = r_out_valid;
    assign o_res_addr   = r_res_addr;
    assign o_status     = r_status;
    assign o_free_count = r_out_cnt;

endmodule

/* rtl/subnet_address_pool_allocator.sv */
// Each item is taken in state IDLE, its first map word is read in RD and checked in CHK;
// an allocate scans k of the 64-bit map words (k from 1 to 16) from the word holding the
// input address, and the result is registered once the output register is free. The scan
// reads one map word per cycle from the single-port bitmap memory; a new item is taken
// only after the last result is registered. Reset, and every write of prefix_length,
// starts a clearing pass over the bitmap, one word per cycle, during which no input transfer is taken.
module subnet_address_pool_allocator
    import sapa_pkg::*;
#(
    parameter int MAX_HOST_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [31:0]          i_s_tdata,   // [31:0] address
    input  logic [0:0]           i_s_tuser,   // [0] command
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,   // [31:0] result_address, [42:32] free_count
    output logic [1:0]           o_m_tuser,   // [1:0] status
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_dp_cmd     cmd;
    t_dp_sts     sts;
    logic [31:0] res_addr;
    logic [10:0] free_count;

    sapa_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sapa_dp #(
        .MAX_HOST_BITS (MAX_HOST_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_cmd     (i_s_tuser[0]),
        .i_in_addr    (i_s_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_res_addr   (res_addr),
        .o_status     (o_m_tuser),
        .o_free_count (free_count)
    );

    assign o_m_tdata   = {5'b0, free_count, res_addr};
    assign o_cfg_ready = 1'b1;

endmodule

/* rtl/sapa_chk.sv */
`include "assert_macros.svh"

module sapa_chk
    import sapa_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_s_tvalid,
    input logic                 o_s_tready,
    input logic [47:0]          o_m_tdata,
    input logic [1:0]           o_m_tuser,
    input logic                 o_m_tvalid,
    input logic                 i_m_tready
);

    `SAPA_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SAPA_ASSERT(a_status_legal, !o_m_tvalid || (o_m_tuser != 2'd3))
    `SAPA_ASSERT(a_fail_addr_zero, !o_m_tvalid || (o_m_tuser == ST_OK) || (o_m_tdata[31:0] == 32'd0))
    `SAPA_ASSERT_NEXT(a_one_at_a_time, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind subnet_address_pool_allocator sapa_chk u_sapa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);
